// ----- src/cts_pkg.sv -----
// Shared types and codes for the coprocessor task scheduler.
package cts_pkg;

  typedef enum logic [2:0] {
    KIND_SUBMIT    = 3'd0,
    KIND_TICK      = 3'd1,
    KIND_CP_DONE   = 3'd2,
    KIND_DISP_DONE = 3'd3,
    KIND_OTHER     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NOTIFY = 2'd0,
    ACT_START  = 2'd1,
    ACT_YIELD  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    TS_NEW = 2'd0,
    TS_RUN = 2'd1,
    TS_INT = 2'd2,
    TS_FIN = 2'd3
  } task_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN,
    S_SCHED,
    S_PUSH_EVT,
    S_PUSH_SCH
  } ctrl_state_t;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    logic accept;
    logic exec;
    logic drain_step;
    logic drain_end;
    logic sched;
    logic push_evt;
    logic push_sch;
  } cts_cmd_t;

  typedef struct packed {
    logic is_submit;
    logic is_tick;
    logic drain_done;
    logic out_room;
  } cts_status_t;

endpackage

// ----- src/cts_event_if.sv -----
// Event input channel: one beat per submitted task or scheduler event.
interface cts_event_if #(parameter int ID_BITS = 8);
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [ID_BITS-1:0] task_id;
  logic               task_is_audio;
  logic               yielded;

  modport source(output valid, kind, task_id, task_is_audio, yielded, input ready);
  modport sink(input valid, kind, task_id, task_is_audio, yielded, output ready);
endinterface

// ----- src/cts_action_if.sv -----
// Action output channel: notify, start and yield beats toward the coprocessor.
interface cts_action_if #(parameter int ID_BITS = 8);
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [ID_BITS-1:0] task_id_res;
  logic               resume;
  logic               clear_counters;
  logic               last;

  modport source(output valid, action, task_id_res, resume, clear_counters, last,
                 input ready);
  modport sink(input valid, action, task_id_res, resume, clear_counters, last,
               output ready);
endinterface

// ----- src/cts_cfg_if.sv -----
// Configuration write channel carrying the stop_tasks register.
interface cts_cfg_if;
  logic valid;
  logic ready;
  logic stop_tasks;

  modport source(output valid, stop_tasks, input ready);
  modport sink(input valid, stop_tasks, output ready);
endinterface

// ----- src/cts_dp.sv -----
// Scheduler datapath: pending memory, task slots, current task and action queue.
module cts_dp #(
  parameter int GFX_SLOTS     = 2,
  parameter int PENDING_DEPTH = 16,
  parameter int ID_BITS       = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cts_pkg::cts_cmd_t    cmd,
  output cts_pkg::cts_status_t status,
  input  logic [2:0]           in_kind,
  input  logic [ID_BITS-1:0]   in_task_id,
  input  logic                 in_task_is_audio,
  input  logic                 in_yielded,
  input  logic                 cfg_valid,
  input  logic                 cfg_stop_tasks,
  output logic                 cfg_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_action,
  output logic [ID_BITS-1:0]   out_task_id,
  output logic                 out_resume,
  output logic                 out_clear_counters,
  output logic                 out_last
);
  import cts_pkg::*;

  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int GI = (GFX_SLOTS > 1) ? $clog2(GFX_SLOTS) : 1;
  localparam int WW = $clog2(GFX_SLOTS + 1);

  // latched event
  logic [2:0]         kind_q;
  logic [ID_BITS-1:0] id_q;
  logic               audio_q;
  logic               yielded_q;

  logic stop_tasks;

  // pending memory
  logic [ID_BITS:0]   pend_mem [PENDING_DEPTH];
  logic [ID_BITS:0]   rd_data;
  logic [CW-1:0]      pend_count;
  logic [CW-1:0]      rd_ptr;
  logic               rd_pend;
  logic               rd_en;
  logic               pend_full;
  logic               pend_wr;

  // drain collection
  logic               na_valid;
  logic [ID_BITS-1:0] na_id;
  logic [WW-1:0]      wi;
  logic [WW-1:0]      fi;
  logic               ent_audio;
  logic [ID_BITS-1:0] ent_id;
  logic               take_gfx;

  // slots and current task
  logic               audio_valid;
  logic [ID_BITS-1:0] audio_id;
  task_st_t           audio_st;
  logic [GFX_SLOTS-1:0] gfx_valid;
  logic [ID_BITS-1:0] gfx_id [GFX_SLOTS];
  task_st_t           gfx_st [GFX_SLOTS];
  logic               cur_valid;
  logic               cur_audio;
  logic               cur_linked;
  logic [ID_BITS-1:0] cur_id;
  task_st_t           cur_st;

  // results of one event
  logic               held_valid;
  logic [ID_BITS-1:0] held_id;
  logic               sch_valid;
  action_t            sch_action;
  logic [ID_BITS-1:0] sch_id;
  logic               sch_resume;
  logic               sch_clr;

  // action queue
  logic [1:0]         ob_action [OQ_DEPTH];
  logic [ID_BITS-1:0] ob_id     [OQ_DEPTH];
  logic               ob_resume [OQ_DEPTH];
  logic               ob_clr    [OQ_DEPTH];
  logic               ob_last   [OQ_DEPTH];
  logic [OQ_AW-1:0]   owp;
  logic [OQ_AW-1:0]   orp;
  logic [OQ_CW-1:0]   ocnt;
  logic               push;
  logic               pop;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q    <= in_kind;
      id_q      <= in_task_id;
      audio_q   <= in_task_is_audio;
      yielded_q <= in_yielded;
    end
  end

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_tasks <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      stop_tasks <= cfg_stop_tasks;
    end
  end

  assign status.is_submit  = (kind_q == KIND_SUBMIT);
  assign status.is_tick    = (kind_q == KIND_TICK);
  assign status.drain_done = (rd_ptr == pend_count) && !rd_pend;
  assign status.out_room   = (ocnt <= OQ_CW'(OQ_DEPTH - 2));

  assign pend_full = (pend_count == CW'(PENDING_DEPTH));
  assign pend_wr   = cmd.exec && status.is_submit && !pend_full;
  assign rd_en     = cmd.drain_step && (rd_ptr != pend_count);

  always_ff @(posedge clk) begin
    if (pend_wr) begin
      pend_mem[pend_count[PW-1:0]] <= {audio_q, id_q};
    end
    if (rd_en) begin
      rd_data <= pend_mem[rd_ptr[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
      rd_ptr     <= '0;
      rd_pend    <= 1'b0;
    end else begin
      if (pend_wr) begin
        pend_count <= pend_count + CW'(1);
      end else if (cmd.drain_end) begin
        pend_count <= '0;
      end
      if (cmd.exec) begin
        rd_ptr  <= '0;
        rd_pend <= 1'b0;
      end else if (cmd.drain_step) begin
        rd_pend <= rd_en;
        if (rd_en) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
      end
    end
  end

  // lowest free graphics slot
  always_comb begin
    fi = WW'(GFX_SLOTS);
    for (int j = GFX_SLOTS - 1; j >= 0; j--) begin
      if (!gfx_valid[j]) begin
        fi = WW'(j);
      end
    end
  end

  assign ent_audio = rd_data[ID_BITS];
  assign ent_id    = rd_data[ID_BITS-1:0];
  assign take_gfx  = rd_pend && !ent_audio && (wi < WW'(GFX_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_valid <= 1'b0;
      gfx_valid   <= '0;
      cur_valid   <= 1'b0;
      cur_linked  <= 1'b0;
      held_valid  <= 1'b0;
      sch_valid   <= 1'b0;
      na_valid    <= 1'b0;
      wi          <= '0;
    end else begin
      if (cmd.exec) begin
        held_valid <= 1'b0;
        case (kind_q)
          KIND_TICK: begin
            na_valid <= 1'b0;
            wi       <= fi;
            // slots from the first free one are refilled by this drain
            for (int j = 0; j < GFX_SLOTS; j++) begin
              if (WW'(j) >= fi) begin
                gfx_valid[j] <= 1'b0;
                gfx_id[j]    <= '0;
                gfx_st[j]    <= TS_NEW;
              end
            end
          end
          KIND_CP_DONE: begin
            if (cur_valid) begin
              cur_valid  <= 1'b0;
              cur_linked <= 1'b0;
              if (cur_st == TS_INT) begin
                if (!yielded_q) begin
                  cur_st <= TS_FIN;
                  if (cur_linked && !cur_audio) begin
                    gfx_st[0] <= TS_FIN;
                  end
                end
              end else begin
                cur_st <= TS_FIN;
                if (cur_linked && !cur_audio) begin
                  gfx_st[0] <= TS_FIN;
                end
                if (cur_audio) begin
                  held_valid  <= 1'b1;
                  held_id     <= cur_id;
                  audio_valid <= 1'b0;
                  audio_st    <= TS_NEW;
                end
              end
            end
          end
          KIND_DISP_DONE: begin
            if (gfx_valid[0]) begin
              held_valid <= 1'b1;
              held_id    <= gfx_id[0];
            end
            for (int j = 0; j < GFX_SLOTS - 1; j++) begin
              gfx_valid[j] <= gfx_valid[j+1];
              gfx_id[j]    <= gfx_id[j+1];
              gfx_st[j]    <= gfx_st[j+1];
            end
            gfx_valid[GFX_SLOTS-1] <= 1'b0;
            gfx_id[GFX_SLOTS-1]    <= '0;
            gfx_st[GFX_SLOTS-1]    <= TS_NEW;
            cur_linked             <= 1'b0;
          end
          default: ;
        endcase
      end

      if (rd_pend) begin
        if (ent_audio && !na_valid) begin
          na_valid <= 1'b1;
          na_id    <= ent_id;
        end
        if (take_gfx) begin
          gfx_valid[wi[GI-1:0]] <= 1'b1;
          gfx_id[wi[GI-1:0]]    <= ent_id;
          gfx_st[wi[GI-1:0]]    <= TS_NEW;
          wi                    <= wi + WW'(1);
        end
      end

      if (cmd.drain_end && !audio_valid) begin
        audio_valid <= na_valid;
        audio_id    <= na_valid ? na_id : '0;
        audio_st    <= TS_NEW;
      end

      if (cmd.sched) begin
        sch_valid <= 1'b0;
        if (!stop_tasks) begin
          if (audio_valid) begin
            if (cur_valid) begin
              if (!cur_audio) begin
                cur_st <= TS_INT;
                if (cur_linked) begin
                  gfx_st[0] <= TS_INT;
                end
                sch_valid  <= 1'b1;
                sch_action <= ACT_YIELD;
                sch_id     <= cur_id;
                sch_resume <= 1'b0;
                sch_clr    <= 1'b0;
              end
            end else begin
              cur_valid  <= 1'b1;
              cur_audio  <= 1'b1;
              cur_linked <= 1'b0;
              cur_id     <= audio_id;
              cur_st     <= TS_RUN;
              audio_st   <= TS_RUN;
              sch_valid  <= 1'b1;
              sch_action <= ACT_START;
              sch_id     <= audio_id;
              sch_resume <= (audio_st == TS_INT);
              sch_clr    <= 1'b0;
            end
          end else if (!cur_valid && gfx_valid[0] && gfx_st[0] != TS_FIN) begin
            cur_valid  <= 1'b1;
            cur_audio  <= 1'b0;
            cur_linked <= 1'b1;
            cur_id     <= gfx_id[0];
            cur_st     <= TS_RUN;
            gfx_st[0]  <= TS_RUN;
            sch_valid  <= 1'b1;
            sch_action <= ACT_START;
            sch_id     <= gfx_id[0];
            sch_resume <= (gfx_st[0] == TS_INT);
            sch_clr    <= 1'b1;
          end
        end
      end
    end
  end

  assign push = (cmd.push_evt && held_valid) || (cmd.push_sch && sch_valid);
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      if (cmd.push_evt) begin
        ob_action[owp] <= ACT_NOTIFY;
        ob_id[owp]     <= held_id;
        ob_resume[owp] <= 1'b0;
        ob_clr[owp]    <= 1'b0;
        ob_last[owp]   <= !sch_valid;
      end else begin
        ob_action[owp] <= sch_action;
        ob_id[owp]     <= sch_id;
        ob_resume[owp] <= sch_resume;
        ob_clr[owp]    <= sch_clr;
        ob_last[owp]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (push) begin
        owp <= owp + OQ_AW'(1);
      end
      if (pop) begin
        orp <= orp + OQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   ocnt <= ocnt + OQ_CW'(1);
        2'b01:   ocnt <= ocnt - OQ_CW'(1);
        default: ocnt <= ocnt;
      endcase
    end
  end

  assign out_valid          = (ocnt != '0);
  assign out_action         = ob_action[orp];
  assign out_task_id        = ob_id[orp];
  assign out_resume         = ob_resume[orp];
  assign out_clear_counters = ob_clr[orp];
  assign out_last           = ob_last[orp];

endmodule

// ----- src/cts_ctrl.sv -----
// Scheduler controller: sequences event, drain, schedule and action beats.
module cts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cts_pkg::cts_status_t status,
  output cts_pkg::cts_cmd_t    cmd
);
  import cts_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && status.out_room) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.is_submit) begin
          state_next = S_IDLE;
        end else if (status.is_tick) begin
          state_next = S_DRAIN;
        end else begin
          state_next = S_SCHED;
        end
      end
      S_DRAIN: begin
        if (status.drain_done) begin
          state_next = S_SCHED;
        end
      end
      S_SCHED:    state_next = S_PUSH_EVT;
      S_PUSH_EVT: state_next = S_PUSH_SCH;
      S_PUSH_SCH: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        // hold off while the action queue lacks room for two beats
        in_ready   = status.out_room && !rst;
        cmd.accept = in_valid && status.out_room && !rst;
      end
      S_EXEC:  cmd.exec = 1'b1;
      S_DRAIN: begin
        cmd.drain_step = !status.drain_done;
        cmd.drain_end  = status.drain_done;
      end
      S_SCHED:    cmd.sched    = 1'b1;
      S_PUSH_EVT: cmd.push_evt = 1'b1;
      S_PUSH_SCH: cmd.push_sch = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- src/coprocessor_task_scheduler_unit.sv -----
// Top level of the coprocessor task scheduler.
// Takes one event beat at a time. A submit is written to the pending memory; coprocessor
// done, display done and other events go straight to scheduling; a frame tick first
// drains the pending memory through its single read port, one entry per cycle, before
// scheduling. Each event yields up to two action beats, which wait in a four-entry
// action queue; a new event is taken only while that queue has room for two beats.
// Write the stop_tasks register only while no event is in flight; it applies from the
// next event taken.
module coprocessor_task_scheduler_unit #(
  parameter int GFX_SLOTS     = 2,
  parameter int PENDING_DEPTH = 16,
  parameter int ID_BITS       = 8
) (
  input logic        clk,
  input logic        rst,
  cts_event_if.sink  events,
  cts_action_if.source actions,
  cts_cfg_if.sink    cfg
);
  import cts_pkg::*;

  cts_cmd_t    cmd;
  cts_status_t status;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (events.valid),
    .in_ready (events.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cts_dp #(
    .GFX_SLOTS     (GFX_SLOTS),
    .PENDING_DEPTH (PENDING_DEPTH),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .in_kind            (events.kind),
    .in_task_id         (events.task_id),
    .in_task_is_audio   (events.task_is_audio),
    .in_yielded         (events.yielded),
    .cfg_valid          (cfg.valid),
    .cfg_stop_tasks     (cfg.stop_tasks),
    .cfg_ready          (cfg.ready),
    .out_valid          (actions.valid),
    .out_ready          (actions.ready),
    .out_action         (actions.action),
    .out_task_id        (actions.task_id_res),
    .out_resume         (actions.resume),
    .out_clear_counters (actions.clear_counters),
    .out_last           (actions.last)
  );

endmodule
